/* sv/kfd_pkg.sv */
// kfd_pkg: shared types and constants for the kiss frame decoder
// used by kfd_step and kiss_frame_decoder_core; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package kfd_pkg;

	localparam logic [7:0] FEND  = 8'hC0;
	localparam logic [7:0] FESC  = 8'hDB;
	localparam logic [7:0] TFEND = 8'hDC;
	localparam logic [7:0] TFESC = 8'hDD;

	localparam logic [7:0] TYPE_DATA = 8'h00;
	localparam logic [7:0] TYPE_ALT  = 8'h06;

	localparam logic [2:0] CALLSIGN_LEN = 3'd6;
	localparam logic [7:0] INDEX_MAX    = 8'd254;

	localparam logic        DISCARD_CALLSIGN_RST = 1'b0;
	localparam logic [15:0] TIMEOUT_TICKS_RST    = 16'd1000;

	localparam int unsigned CFG_DATA_W = 16;

	typedef enum logic [0:0] {
		CFG_DISCARD_CALLSIGN = 1'b0,
		CFG_TIMEOUT_TICKS    = 1'b1
	} cfg_index_t;

	typedef enum logic [1:0] {
		REQ_BYTE = 2'd0,
		REQ_TICK = 2'd1,
		REQ_SKIP = 2'd2,
		REQ_NONE = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_PAYLOAD = 2'd0,
		ST_START   = 2'd1,
		ST_END     = 2'd2,
		ST_TIMEOUT = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		MODE_HUNT = 3'd0,
		MODE_CALL = 3'd1,
		MODE_DATA = 3'd2,
		MODE_ESC  = 3'd3,
		MODE_SKIP = 3'd4
	} mode_t;

	typedef struct packed {
		mode_t       mode;
		logic        seen_fend;
		logic [2:0]  callsign_left;
		logic [7:0]  payload_count;
		logic [7:0]  current_type;
		logic [15:0] silence_count;
	} state_t;

	typedef struct packed {
		logic       valid;
		status_t    status;
		logic [7:0] data;
	} result_t;

endpackage

`default_nettype wire

/* sv/kfd_step.sv */
// kfd_step: next-state and result logic for one request beat
// depends on kfd_pkg
`timescale 1ns / 1ps
`default_nettype none

module kfd_step (
	input  kfd_pkg::state_t  st,
	input  logic [1:0]       req_type,
	input  logic [7:0]       rx_byte,
	input  logic             discard_callsign,
	input  logic [15:0]      timeout_ticks,
	output kfd_pkg::state_t  nxt,
	output kfd_pkg::result_t res
);

	logic [2:0] call_dec;
	logic [7:0] count_inc;
	logic       is_fend;
	logic       is_type;
	logic       tick_expired;
	logic [7:0] unesc;

	assign call_dec     = (st.callsign_left != 3'd0) ? st.callsign_left - 3'd1 : 3'd0;
	assign count_inc    = (st.payload_count < kfd_pkg::INDEX_MAX) ?
		st.payload_count + 8'd1 : st.payload_count;
	assign is_fend      = (rx_byte == kfd_pkg::FEND);
	assign is_type      = (rx_byte == kfd_pkg::TYPE_DATA) || (rx_byte == kfd_pkg::TYPE_ALT);
	assign tick_expired = !(st.silence_count < timeout_ticks);
	assign unesc        = (rx_byte == kfd_pkg::TFEND) ? kfd_pkg::FEND :
		(rx_byte == kfd_pkg::TFESC) ? kfd_pkg::FESC : rx_byte;

	// next state
	always_comb begin
		nxt = st;
		case (kfd_pkg::req_t'(req_type))
			kfd_pkg::REQ_BYTE: begin
				nxt.silence_count = 16'd0;
				case (st.mode)
					kfd_pkg::MODE_HUNT: begin
						if (is_fend) begin
							nxt.seen_fend = 1'b1;
						end else if (st.seen_fend && is_type) begin
							nxt.seen_fend    = 1'b0;
							nxt.current_type = rx_byte;
							if (discard_callsign) begin
								nxt.mode          = kfd_pkg::MODE_CALL;
								nxt.callsign_left = kfd_pkg::CALLSIGN_LEN;
							end else begin
								nxt.mode          = kfd_pkg::MODE_DATA;
								nxt.payload_count = 8'd0;
							end
						end else begin
							nxt.seen_fend = 1'b0;
						end
					end
					kfd_pkg::MODE_CALL: begin
						nxt.callsign_left = call_dec;
						if (call_dec == 3'd0) begin
							nxt.mode          = kfd_pkg::MODE_DATA;
							nxt.payload_count = 8'd0;
						end
					end
					kfd_pkg::MODE_DATA: begin
						if (is_fend) begin
							nxt.mode      = kfd_pkg::MODE_HUNT;
							nxt.seen_fend = 1'b1;
						end else begin
							nxt.payload_count = count_inc;
							if (rx_byte == kfd_pkg::FESC) begin
								nxt.mode = kfd_pkg::MODE_ESC;
							end
						end
					end
					kfd_pkg::MODE_ESC: begin
						if (is_fend) begin
							nxt.mode      = kfd_pkg::MODE_HUNT;
							nxt.seen_fend = 1'b1;
						end else begin
							nxt.mode = kfd_pkg::MODE_DATA;
						end
					end
					default: begin
						if (is_fend) begin
							nxt.mode      = kfd_pkg::MODE_HUNT;
							nxt.seen_fend = 1'b1;
						end
					end
				endcase
			end
			kfd_pkg::REQ_TICK: begin
				if (!tick_expired) begin
					nxt.silence_count = st.silence_count + 16'd1;
				end else begin
					nxt.silence_count = 16'd0;
					nxt.seen_fend     = 1'b0;
					if (st.mode != kfd_pkg::MODE_HUNT) begin
						nxt.mode          = kfd_pkg::MODE_HUNT;
						nxt.callsign_left = 3'd0;
					end
				end
			end
			kfd_pkg::REQ_SKIP: begin
				if (st.mode == kfd_pkg::MODE_CALL || st.mode == kfd_pkg::MODE_DATA ||
						st.mode == kfd_pkg::MODE_ESC) begin
					nxt.mode          = kfd_pkg::MODE_SKIP;
					nxt.callsign_left = 3'd0;
				end
			end
			default: begin
				nxt = st;
			end
		endcase
	end

	// result
	always_comb begin
		res.valid  = 1'b0;
		res.status = kfd_pkg::ST_PAYLOAD;
		res.data   = 8'd0;
		case (kfd_pkg::req_t'(req_type))
			kfd_pkg::REQ_BYTE: begin
				case (st.mode)
					kfd_pkg::MODE_HUNT: begin
						if (!is_fend && st.seen_fend && is_type && !discard_callsign) begin
							res.valid  = 1'b1;
							res.status = kfd_pkg::ST_START;
						end
					end
					kfd_pkg::MODE_CALL: begin
						if (call_dec == 3'd0) begin
							res.valid  = 1'b1;
							res.status = kfd_pkg::ST_START;
						end
					end
					kfd_pkg::MODE_DATA: begin
						if (is_fend) begin
							res.valid  = 1'b1;
							res.status = kfd_pkg::ST_END;
						end else if (rx_byte != kfd_pkg::FESC) begin
							res.valid = 1'b1;
							res.data  = rx_byte;
						end
					end
					kfd_pkg::MODE_ESC: begin
						res.valid = 1'b1;
						if (is_fend) begin
							res.status = kfd_pkg::ST_END;
						end else begin
							res.data = unesc;
						end
					end
					default: begin
						if (is_fend) begin
							res.valid  = 1'b1;
							res.status = kfd_pkg::ST_END;
						end
					end
				endcase
			end
			kfd_pkg::REQ_TICK: begin
				if (tick_expired && st.mode != kfd_pkg::MODE_HUNT) begin
					res.valid  = 1'b1;
					res.status = kfd_pkg::ST_TIMEOUT;
				end
			end
			default: begin
				res.valid = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

/* sv/kiss_frame_decoder_core.sv */
// kiss_frame_decoder_core: kiss deframer top level, input register, state, result register
// depends on kfd_pkg and kfd_step
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// Input channel (in_valid / in_stall) carries one request beat: req_type selects a
// received byte (rx_byte), a tick, a skip-rest-of-frame request, or no request.
// Output channel (out_valid / out_stall) carries at most one result beat per request:
// status (payload byte, frame start, frame end, timeout), the un-escaped data_byte,
// the frame_type of the current frame and byte_index, the payload count so far.
// A beat accepted into the input register is decoded by kfd_step and its result is
// registered in the result register, from which it drives out_valid.
// Throughput: one request per clock unless out_stall holds a waiting result; the decode is
// a single pass between the input register and the result register, and requests without
// a result leave no bubble. When the receiver holds out_stall with a result waiting, the
// input register holds its beat and in_stall rises in the same cycle; nothing is dropped.
// Config: cfg_we with cfg_index 0 writes discard_callsign, index 1 writes
// timeout_ticks; write only while the block is idle.
// Reset (arst_n low) empties both registers, hunts for a frame start and restores
// discard_callsign = 0 and timeout_ticks = 1000.
module kiss_frame_decoder_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [kfd_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      req_type,
	input  logic [7:0]                      rx_byte,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [1:0]                      status,
	output logic [7:0]                      data_byte,
	output logic [7:0]                      frame_type,
	output logic [7:0]                      byte_index
);

	logic             discard_callsign_q;
	logic [15:0]      timeout_ticks_q;
	logic             valid_s1;
	logic [1:0]       req_type_s1;
	logic [7:0]       rx_byte_s1;
	kfd_pkg::state_t  state_q;
	kfd_pkg::state_t  state_nxt;
	kfd_pkg::result_t res;
	logic             out_valid_q;
	logic [1:0]       status_q;
	logic [7:0]       data_byte_q;
	logic [7:0]       frame_type_q;
	logic [7:0]       byte_index_q;
	logic             out_ready;
	logic             advance;

	assign out_ready = !out_valid_q || !out_stall;
	assign advance   = valid_s1 && out_ready;
	assign in_stall  = valid_s1 && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			discard_callsign_q <= kfd_pkg::DISCARD_CALLSIGN_RST;
			timeout_ticks_q    <= kfd_pkg::TIMEOUT_TICKS_RST;
		end else if (cfg_we) begin
			case (kfd_pkg::cfg_index_t'(cfg_index))
				kfd_pkg::CFG_DISCARD_CALLSIGN: discard_callsign_q <= cfg_data[0];
				kfd_pkg::CFG_TIMEOUT_TICKS:    timeout_ticks_q    <= cfg_data[15:0];
				default:                       timeout_ticks_q    <= timeout_ticks_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_type_s1 <= req_type;
			rx_byte_s1  <= rx_byte;
		end
	end

	kfd_step u_step (
		.st               (state_q),
		.req_type         (req_type_s1),
		.rx_byte          (rx_byte_s1),
		.discard_callsign (discard_callsign_q),
		.timeout_ticks    (timeout_ticks_q),
		.nxt              (state_nxt),
		.res              (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode          <= kfd_pkg::MODE_HUNT;
			state_q.seen_fend     <= 1'b0;
			state_q.callsign_left <= 3'd0;
			state_q.payload_count <= 8'd0;
			state_q.current_type  <= 8'd0;
			state_q.silence_count <= 16'd0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= advance && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			status_q     <= res.status;
			data_byte_q  <= res.data;
			frame_type_q <= state_nxt.current_type;
			byte_index_q <= state_nxt.payload_count;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign data_byte  = data_byte_q;
	assign frame_type = frame_type_q;
	assign byte_index = byte_index_q;

`ifndef SYNTHESIS
	a_index_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (byte_index <= kfd_pkg::INDEX_MAX))
		else $error("byte_index above saturation limit");

	a_start_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == kfd_pkg::ST_START) |-> (byte_index == 8'd0))
		else $error("frame start with nonzero byte_index");

	a_type_legal: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.current_type == kfd_pkg::TYPE_DATA) ||
		(state_q.current_type == kfd_pkg::TYPE_ALT))
		else $error("illegal frame type held");

	a_callsign_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.mode != kfd_pkg::MODE_CALL) |-> (state_q.callsign_left == 3'd0))
		else $error("callsign count left outside callsign mode");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked result");
`endif

endmodule

`default_nettype wire
